/* design/bgdc_pkg.sv */
// Shared types and constants for the button gesture and dial controller.
// Depends on nothing; all other files but the checker use it by scoped names.
`timescale 1ns / 1ps

package bgdc_pkg;

  // Configuration port geometry
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 2;

  // Register field widths
  localparam int HOLD_W     = 16;
  localparam int TAP_W      = 16;
  localparam int DEADBAND_W = 14;

  // Register reset values
  localparam logic [HOLD_W-1:0]     HOLD_TICKS_RST    = 16'd3000;
  localparam logic [TAP_W-1:0]      TAP_WINDOW_RST    = 16'd300;
  localparam logic [DEADBAND_W-1:0] SEND_DEADBAND_RST = 14'd4;

  // Register indexes on the configuration port
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_HOLD_TICKS       = 2'd0,
    CFG_TAP_WINDOW_TICKS = 2'd1,
    CFG_SEND_DEADBAND    = 2'd2
  } cfg_index_t;

  // Register set as seen by the datapath
  typedef struct packed {
    logic [HOLD_W-1:0]     hold_ticks;
    logic [TAP_W-1:0]      tap_window_ticks;
    logic [DEADBAND_W-1:0] send_deadband;
  } cfg_regs_t;

  // Gesture events handed to the dial and output logic
  typedef struct packed {
    logic clear_fault;
    logic cycle_display;
    logic toggle_mode;
  } gesture_evt_t;

endpackage

/* design/button_gesture_and_dial_controller_unit.sv */
// Button gesture and dial controller. Takes one tick item per clock while the
// output is not stalled: the item is captured in an input register, the gesture
// and dial logic runs in a single pass, and the result is loaded into an output
// register when the item leaves the input register. Throughput is one item per
// cycle, set by that single-pass tick logic, unless the output stalls; a stalled
// output register holds its result while the input register still takes one more
// item. Configuration writes take effect on the next edge.
// Depends on bgdc_pkg, bgdc_cfg, bgdc_gesture and bgdc_dial.
`timescale 1ns / 1ps

module button_gesture_and_dial_controller_unit #(
  parameter int ANGLE_BITS = 14,
  parameter int TIMER_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Tick items
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_button_pressed,
  input  logic [ANGLE_BITS-1:0]            in_dial_angle,
  input  logic                             in_motor_faulted,
  // Results
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_clear_fault,
  output logic                             out_cycle_display,
  output logic                             out_mode_write,
  output logic                             out_drive_mode,
  output logic                             out_velocity_write,
  output logic signed [ANGLE_BITS:0]       out_velocity_command,
  // Configuration
  input  logic                             cfg_write_en,
  input  logic [bgdc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [bgdc_pkg::CFG_DATA_W-1:0]  cfg_data
);

  bgdc_pkg::cfg_regs_t    regs;
  bgdc_pkg::gesture_evt_t evt;

  logic                  s1_valid_r, s1_valid_nxt;
  logic                  s1_pressed_r, s1_faulted_r;
  logic [ANGLE_BITS-1:0] s1_angle_r;
  logic                  advance, take_in;

  logic                  mode_write, drive_mode, velocity_write;
  logic signed [ANGLE_BITS:0] velocity_command;

  logic                       out_valid_r, out_valid_nxt;
  logic                       out_clear_r, out_cycle_r, out_mwrite_r, out_mode_r, out_vwrite_r;
  logic signed [ANGLE_BITS:0] out_cmd_r;

  // Handshake: move on when the output register is free or being drained
  assign advance  = s1_valid_r & (~out_valid_r | out_ready);
  assign in_ready = ~s1_valid_r | advance;
  assign take_in  = in_valid & in_ready;

  assign s1_valid_nxt  = take_in | (s1_valid_r & ~advance);
  assign out_valid_nxt = advance | (out_valid_r & ~out_ready);

  bgdc_cfg u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .regs         (regs)
  );

  bgdc_gesture #(.TIMER_BITS(TIMER_BITS)) u_gesture (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .pressed (s1_pressed_r),
    .faulted (s1_faulted_r),
    .regs    (regs),
    .evt     (evt)
  );

  bgdc_dial #(.ANGLE_BITS(ANGLE_BITS)) u_dial (
    .clk              (clk),
    .rst_n            (rst_n),
    .advance          (advance),
    .angle            (s1_angle_r),
    .toggle_mode      (evt.toggle_mode),
    .send_deadband    (regs.send_deadband),
    .mode_write       (mode_write),
    .drive_mode       (drive_mode),
    .velocity_write   (velocity_write),
    .velocity_command (velocity_command)
  );

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Capture the item
  always_ff @(posedge clk) begin
    if (take_in) begin
      s1_pressed_r <= in_button_pressed;
      s1_angle_r   <= in_dial_angle;
      s1_faulted_r <= in_motor_faulted;
    end
  end

  // Load the result
  always_ff @(posedge clk) begin
    if (advance) begin
      out_clear_r  <= evt.clear_fault;
      out_cycle_r  <= evt.cycle_display;
      out_mwrite_r <= mode_write;
      out_mode_r   <= drive_mode;
      out_vwrite_r <= velocity_write;
      out_cmd_r    <= velocity_command;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_clear_fault      = out_clear_r;
  assign out_cycle_display    = out_cycle_r;
  assign out_mode_write       = out_mwrite_r;
  assign out_drive_mode       = out_mode_r;
  assign out_velocity_write   = out_vwrite_r;
  assign out_velocity_command = out_cmd_r;

endmodule

/* design/bgdc_cfg.sv */
// Configuration register file: hold time, tap window and send deadband.
// Depends on bgdc_pkg.
`timescale 1ns / 1ps

module bgdc_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_write_en,
  input  logic [bgdc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [bgdc_pkg::CFG_DATA_W-1:0]  cfg_data,
  output bgdc_pkg::cfg_regs_t              regs
);

  bgdc_pkg::cfg_regs_t regs_r, regs_nxt;

  // Decode the write; unknown indexes are dropped
  always_comb begin
    regs_nxt = regs_r;
    if (cfg_write_en) begin
      case (cfg_index)
        bgdc_pkg::CFG_HOLD_TICKS:
          regs_nxt.hold_ticks = cfg_data[bgdc_pkg::HOLD_W-1:0];
        bgdc_pkg::CFG_TAP_WINDOW_TICKS:
          regs_nxt.tap_window_ticks = cfg_data[bgdc_pkg::TAP_W-1:0];
        bgdc_pkg::CFG_SEND_DEADBAND:
          regs_nxt.send_deadband = cfg_data[bgdc_pkg::DEADBAND_W-1:0];
        default: regs_nxt = regs_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.hold_ticks       <= bgdc_pkg::HOLD_TICKS_RST;
      regs_r.tap_window_ticks <= bgdc_pkg::TAP_WINDOW_RST;
      regs_r.send_deadband    <= bgdc_pkg::SEND_DEADBAND_RST;
    end else begin
      regs_r <= regs_nxt;
    end
  end

  assign regs = regs_r;

endmodule

/* design/bgdc_gesture.sv */
// Button gesture detector: edges, long hold, tap and double tap timing.
// Depends on bgdc_pkg; state advances once per tick item.
`timescale 1ns / 1ps

module bgdc_gesture #(
  parameter int TIMER_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    advance,
  input  logic                    pressed,
  input  logic                    faulted,
  input  bgdc_pkg::cfg_regs_t     regs,
  output bgdc_pkg::gesture_evt_t  evt
);

  // Compare width covers both the counter and the 16-bit thresholds
  localparam int CMP_W = (TIMER_BITS > bgdc_pkg::HOLD_W) ? TIMER_BITS : bgdc_pkg::HOLD_W;

  logic                  button_prev_r, button_prev_nxt;
  logic                  consumed_r, consumed_nxt;
  logic [TIMER_BITS-1:0] hold_cnt_r, hold_cnt_nxt;
  logic                  tap_pending_r, tap_pending_nxt;
  logic [TIMER_BITS-1:0] tap_cnt_r, tap_cnt_nxt;

  logic                  rise, fall, consumed_a, hold_fire;
  logic [TIMER_BITS-1:0] tap_cnt_a;
  logic                  tap_pending_a;

  // One tick of gesture logic
  always_comb begin
    rise = pressed & ~button_prev_r;
    fall = ~pressed & button_prev_r;
    consumed_a = rise ? 1'b0 : consumed_r;

    // Hold counter saturates; cleared while released
    if (pressed) begin
      hold_cnt_nxt = (hold_cnt_r == {TIMER_BITS{1'b1}}) ? hold_cnt_r
                                                        : hold_cnt_r + 1'b1;
    end else begin
      hold_cnt_nxt = '0;
    end
    hold_fire = pressed & ~consumed_a &
                (CMP_W'(hold_cnt_nxt) >= CMP_W'(regs.hold_ticks));
    consumed_nxt = consumed_a | hold_fire;

    evt.clear_fault   = hold_fire & faulted;
    evt.cycle_display = 1'b0;
    evt.toggle_mode   = 1'b0;

    // Release of an unconsumed press is a tap
    tap_pending_a = tap_pending_r;
    tap_cnt_a     = tap_cnt_r;
    if (fall && !consumed_nxt) begin
      if (tap_pending_r) begin
        evt.cycle_display = 1'b1;
        tap_pending_a     = 1'b0;
      end else begin
        tap_pending_a = 1'b1;
      end
      tap_cnt_a = '0;
    end

    // Count the tap window; expiry of a lone tap toggles the mode
    tap_pending_nxt = tap_pending_a;
    tap_cnt_nxt     = tap_cnt_a;
    if (tap_pending_a) begin
      tap_cnt_nxt = (tap_cnt_a == {TIMER_BITS{1'b1}}) ? tap_cnt_a : tap_cnt_a + 1'b1;
      if (CMP_W'(tap_cnt_nxt) >= CMP_W'(regs.tap_window_ticks)) begin
        evt.toggle_mode = 1'b1;
        tap_pending_nxt = 1'b0;
        tap_cnt_nxt     = '0;
      end
    end

    button_prev_nxt = pressed;
  end

  // Advance state only when a tick item leaves the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      button_prev_r <= 1'b0;
      consumed_r    <= 1'b0;
      hold_cnt_r    <= '0;
      tap_pending_r <= 1'b0;
      tap_cnt_r     <= '0;
    end else if (advance) begin
      button_prev_r <= button_prev_nxt;
      consumed_r    <= consumed_nxt;
      hold_cnt_r    <= hold_cnt_nxt;
      tap_pending_r <= tap_pending_nxt;
      tap_cnt_r     <= tap_cnt_nxt;
    end
  end

endmodule

/* design/bgdc_dial.sv */
// Run mode, dial accumulation with seam wrap and clamp, and change-only
// mode and velocity writes. Depends on bgdc_pkg.
`timescale 1ns / 1ps

module bgdc_dial #(
  parameter int ANGLE_BITS = 14
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         advance,
  input  logic [ANGLE_BITS-1:0]        angle,
  input  logic                         toggle_mode,
  input  logic [bgdc_pkg::DEADBAND_W-1:0] send_deadband,
  output logic                         mode_write,
  output logic                         drive_mode,
  output logic                         velocity_write,
  output logic signed [ANGLE_BITS:0]   velocity_command
);

  localparam int RW    = ANGLE_BITS + 1;
  localparam int SW    = ANGLE_BITS + 2;
  localparam int CMP_W = (SW > bgdc_pkg::DEADBAND_W + 1) ? SW : bgdc_pkg::DEADBAND_W + 1;
  localparam logic signed [SW-1:0] HALF_S = SW'(2 ** (ANGLE_BITS - 1));
  localparam logic signed [SW-1:0] FULL_S = SW'(2 ** ANGLE_BITS);

  logic                  run_r, run_nxt;
  logic [ANGLE_BITS-1:0] prev_r, prev_nxt;
  logic signed [RW-1:0]  acc_r, acc_nxt;
  logic                  mode_sent_r, mode_sent_nxt;
  logic signed [RW-1:0]  vel_sent_r, vel_sent_nxt;
  logic                  seeded_r;

  logic signed [SW-1:0]  delta, sum, diff;
  logic signed [RW-1:0]  request;
  logic [SW-1:0]         diff_mag;

  always_comb begin
    // Wrap the angle step across the seam
    delta = $signed({2'b00, angle}) - $signed({2'b00, prev_r});
    if (delta > HALF_S) begin
      delta = delta - FULL_S;
    end else if (delta < -HALF_S) begin
      delta = delta + FULL_S;
    end

    // Accumulate and clamp to half a turn each way
    sum = $signed({acc_r[RW-1], acc_r}) + delta;
    if (sum > HALF_S) begin
      sum = HALF_S;
    end
    if (sum < -HALF_S) begin
      sum = -HALF_S;
    end

    run_nxt  = run_r;
    prev_nxt = prev_r;
    acc_nxt  = acc_r;
    request  = '0;
    if (!run_r) begin
      if (toggle_mode) begin
        run_nxt  = 1'b1;
        prev_nxt = angle;
        acc_nxt  = '0;
      end
    end else begin
      if (toggle_mode) begin
        run_nxt = 1'b0;
      end
      prev_nxt = angle;
      acc_nxt  = sum[RW-1:0];
      request  = sum[RW-1:0];
    end

    // Write mode on change, velocity past the deadband, both on the first tick
    mode_write    = ~seeded_r | (run_nxt != mode_sent_r);
    mode_sent_nxt = mode_write ? run_nxt : mode_sent_r;

    diff     = $signed({request[RW-1], request}) - $signed({vel_sent_r[RW-1], vel_sent_r});
    diff_mag = diff[SW-1] ? $unsigned(-diff) : $unsigned(diff);
    velocity_write = ~seeded_r | (CMP_W'(diff_mag) > CMP_W'(send_deadband));
    vel_sent_nxt   = velocity_write ? request : vel_sent_r;

    drive_mode       = run_nxt;
    velocity_command = vel_sent_nxt;
  end

  // Advance state only when a tick item leaves the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r       <= 1'b0;
      prev_r      <= '0;
      acc_r       <= '0;
      mode_sent_r <= 1'b0;
      vel_sent_r  <= '0;
      seeded_r    <= 1'b0;
    end else if (advance) begin
      run_r       <= run_nxt;
      prev_r      <= prev_nxt;
      acc_r       <= acc_nxt;
      mode_sent_r <= mode_sent_nxt;
      vel_sent_r  <= vel_sent_nxt;
      seeded_r    <= 1'b1;
    end
  end

endmodule

/* design/bgdc_checker.sv */
// Port-level checks for the button gesture and dial controller, bound to
// the top level. Depends only on the top level's ports.
`timescale 1ns / 1ps

module bgdc_checker #(
  parameter int ANGLE_BITS = 14
) (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic                       out_clear_fault,
  input logic                       out_cycle_display,
  input logic                       out_mode_write,
  input logic                       out_drive_mode,
  input logic                       out_velocity_write,
  input logic signed [ANGLE_BITS:0] out_velocity_command
);

  localparam logic signed [ANGLE_BITS:0] HALF_C = (ANGLE_BITS + 1)'(2 ** (ANGLE_BITS - 1));

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_velocity_command) &&
      $stable(out_drive_mode) && $stable(out_mode_write) &&
      $stable(out_velocity_write) && $stable(out_clear_fault) && $stable(out_cycle_display))
    else $error("result changed while stalled");

  // Empty output register always frees the input side
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // A hold fires while pressed, a double tap on release: never together
  a_gesture_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_clear_fault && out_cycle_display))
    else $error("fault clear and display cycle in one tick");

  // Command stays within half a turn
  a_cmd_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_velocity_command <= HALF_C) && (out_velocity_command >= -HALF_C))
    else $error("velocity command out of range");

endmodule

bind button_gesture_and_dial_controller_unit bgdc_checker #(.ANGLE_BITS(ANGLE_BITS)) u_bgdc_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_ready             (in_ready),
  .out_valid            (out_valid),
  .out_ready            (out_ready),
  .out_clear_fault      (out_clear_fault),
  .out_cycle_display    (out_cycle_display),
  .out_mode_write       (out_mode_write),
  .out_drive_mode       (out_drive_mode),
  .out_velocity_write   (out_velocity_write),
  .out_velocity_command (out_velocity_command)
);

/* test/tb_button_gesture_and_dial_controller_unit.sv */
// Self-checking bench for the button gesture and dial controller: a tick-level
// predictor in a scoreboard class checks every result against random and directed gestures.
// Depends on bgdc_pkg and button_gesture_and_dial_controller_unit.
`timescale 1ns / 1ps

module tb_button_gesture_and_dial_controller_unit;

  localparam int ANGLE_BITS  = 14;
  localparam int HALF_TURN   = 1 << (ANGLE_BITS - 1);
  localparam int FULL_TURN   = 1 << ANGLE_BITS;
  localparam int TIMER_MAX   = 65535;
  localparam int CYCLE_LIMIT = 800000;
  localparam int CFG_W       = bgdc_pkg::CFG_DATA_W;

  // One result item as the block presents it
  typedef struct packed {
    logic                       clear_fault;
    logic                       cycle_display;
    logic                       mode_write;
    logic                       drive_mode;
    logic                       velocity_write;
    logic signed [ANGLE_BITS:0] velocity_command;
  } tick_result_t;

  // Gesture and dial predictor plus the queue of results still owed
  class gesture_scoreboard;
    logic [bgdc_pkg::HOLD_W-1:0]     hold_ticks;
    logic [bgdc_pkg::TAP_W-1:0]      tap_window;
    logic [bgdc_pkg::DEADBAND_W-1:0] deadband;
    bit btn_prev, consumed, tap_pending, run_mode, mode_sent, seeded;
    int hold_count, tap_count, prev_angle, dial_acc, vel_sent;
    tick_result_t expected_q[$];
    int checked, mismatches, clears, double_taps, toggles, cmd_writes;

    function void reset_model();
      hold_ticks  = bgdc_pkg::HOLD_TICKS_RST;
      tap_window  = bgdc_pkg::TAP_WINDOW_RST;
      deadband    = bgdc_pkg::SEND_DEADBAND_RST;
      btn_prev    = 0;
      consumed    = 0;
      tap_pending = 0;
      run_mode    = 0;
      mode_sent   = 0;
      seeded      = 0;
      hold_count  = 0;
      tap_count   = 0;
      prev_angle  = 0;
      dial_acc    = 0;
      vel_sent    = 0;
      expected_q.delete();
    endfunction

    function void set_reg(bgdc_pkg::cfg_index_t idx, logic [CFG_W-1:0] data);
      case (idx)
        bgdc_pkg::CFG_HOLD_TICKS:       hold_ticks = data[bgdc_pkg::HOLD_W-1:0];
        bgdc_pkg::CFG_TAP_WINDOW_TICKS: tap_window = data[bgdc_pkg::TAP_W-1:0];
        bgdc_pkg::CFG_SEND_DEADBAND:    deadband   = data[bgdc_pkg::DEADBAND_W-1:0];
        default: ;
      endcase
    endfunction

    function int sat_inc(int v);
      return (v >= TIMER_MAX) ? TIMER_MAX : v + 1;
    endfunction

    // Advance the predictor by one accepted tick and queue its result
    function void note_tick(bit pressed, logic [ANGLE_BITS-1:0] angle, bit faulted);
      tick_result_t r;
      bit rise, fall, toggle;
      int request, delta, diff;
      rise    = pressed && !btn_prev;
      fall    = !pressed && btn_prev;
      r       = '0;
      toggle  = 0;
      request = 0;
      btn_prev = pressed;
      if (rise) consumed = 0;

      // long hold: fires once per press, clears only a latched fault
      if (pressed) begin
        hold_count = sat_inc(hold_count);
        if (hold_count >= int'(hold_ticks) && !consumed) begin
          r.clear_fault = faulted;
          consumed = 1;
        end
      end else begin
        hold_count = 0;
      end

      // taps: second one inside the window cycles the display
      if (fall && !consumed) begin
        if (tap_pending) begin
          r.cycle_display = 1;
          tap_pending = 0;
        end else begin
          tap_pending = 1;
        end
        tap_count = 0;
      end
      if (tap_pending) begin
        tap_count = sat_inc(tap_count);
        if (tap_count >= int'(tap_window)) begin
          toggle = 1;
          tap_pending = 0;
          tap_count = 0;
        end
      end

      // dial: wrap the delta across the seam, clamp the sum at half a turn
      if (!run_mode) begin
        if (toggle) begin
          run_mode   = 1;
          prev_angle = int'(angle);
          dial_acc   = 0;
        end
      end else begin
        if (toggle) run_mode = 0;
        delta = int'(angle) - prev_angle;
        if (delta > HALF_TURN) delta -= FULL_TURN;
        else if (delta < -HALF_TURN) delta += FULL_TURN;
        prev_angle = int'(angle);
        dial_acc += delta;
        if (dial_acc > HALF_TURN) dial_acc = HALF_TURN;
        if (dial_acc < -HALF_TURN) dial_acc = -HALF_TURN;
        request = dial_acc;
      end

      // send on change only; the first tick sends both
      if (!seeded || run_mode != mode_sent) begin
        r.mode_write = 1;
        mode_sent = run_mode;
      end
      diff = request - vel_sent;
      if (diff < 0) diff = -diff;
      if (!seeded || diff > int'(deadband)) begin
        r.velocity_write = 1;
        vel_sent = request;
      end
      seeded = 1;
      r.drive_mode       = run_mode;
      r.velocity_command = vel_sent[ANGLE_BITS:0];

      clears      += int'(r.clear_fault);
      double_taps += int'(r.cycle_display);
      toggles     += int'(toggle);
      cmd_writes  += int'(r.velocity_write);
      expected_q.push_back(r);
    endfunction

    function string show(tick_result_t r);
      return $sformatf("clear=%0b cycle=%0b mode_wr=%0b mode=%0b vel_wr=%0b vel=%0d",
                       r.clear_fault, r.cycle_display, r.mode_write, r.drive_mode,
                       r.velocity_write, r.velocity_command);
    endfunction

    // Compare one result with the oldest owed one
    function void check_result(tick_result_t got);
      tick_result_t want;
      string bad;
      checked++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("[%0t] result %0d arrived with nothing owed: %s",
                                       $time, checked, show(got));
        return;
      end
      want = expected_q.pop_front();
      bad = "";
      if (got.clear_fault !== want.clear_fault)           bad = {bad, " clear_fault"};
      if (got.cycle_display !== want.cycle_display)       bad = {bad, " cycle_display"};
      if (got.mode_write !== want.mode_write)             bad = {bad, " mode_write"};
      if (got.drive_mode !== want.drive_mode)             bad = {bad, " drive_mode"};
      if (got.velocity_write !== want.velocity_write)     bad = {bad, " velocity_write"};
      if (got.velocity_command !== want.velocity_command) bad = {bad, " velocity_command"};
      if (bad != "") begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("[%0t] result %0d wrong:%s", $time, checked, bad);
          $display("  expected %s", show(want));
          $display("  actual   %s", show(got));
        end
      end
    endfunction
  endclass

  logic                                 clk;
  logic                                 rst_n;
  logic                                 in_valid;
  logic                                 in_ready;
  logic                                 in_button_pressed;
  logic [ANGLE_BITS-1:0]                in_dial_angle;
  logic                                 in_motor_faulted;
  logic                                 out_valid;
  logic                                 out_ready;
  logic                                 out_clear_fault;
  logic                                 out_cycle_display;
  logic                                 out_mode_write;
  logic                                 out_drive_mode;
  logic                                 out_velocity_write;
  logic signed [ANGLE_BITS:0]           out_velocity_command;
  logic                                 cfg_write_en;
  logic [bgdc_pkg::CFG_INDEX_W-1:0]     cfg_index;
  logic [CFG_W-1:0]                     cfg_data;

  gesture_scoreboard     sb;
  bit                    send_calm;
  bit                    recv_calm;
  int                    recv_stall = 0;
  int                    cycle_count = 0;
  logic [ANGLE_BITS-1:0] dial_pos;
  int                    dial_drift;

  button_gesture_and_dial_controller_unit #(
    .ANGLE_BITS(ANGLE_BITS),
    .TIMER_BITS(16)
  ) dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_button_pressed   (in_button_pressed),
    .in_dial_angle       (in_dial_angle),
    .in_motor_faulted    (in_motor_faulted),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_clear_fault     (out_clear_fault),
    .out_cycle_display   (out_cycle_display),
    .out_mode_write      (out_mode_write),
    .out_drive_mode      (out_drive_mode),
    .out_velocity_write  (out_velocity_write),
    .out_velocity_command(out_velocity_command),
    .cfg_write_en        (cfg_write_en),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("button_gesture_and_dial_controller_unit: mismatch");
      $finish;
    end
  end

  // Predict on every accepted tick
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready)
      sb.note_tick(in_button_pressed, in_dial_angle, in_motor_faulted);
  end

  // Check every accepted result
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result(tick_result_t'{out_clear_fault, out_cycle_display, out_mode_write,
                                     out_drive_mode, out_velocity_write,
                                     out_velocity_command});
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Stall the result side at random, except in calm stretches
  always @(negedge clk) begin
    if (recv_stall > 0) begin
      out_ready <= 1'b0;
      recv_stall = recv_stall - 1;
    end else begin
      out_ready <= 1'b1;
      if (!recv_calm) recv_stall = pick_gap();
    end
  end

  // Length of a press or release stretch around a threshold
  function automatic int pick_len(int thr);
    int lo, hi;
    case ($urandom_range(0, 3))
      0: begin lo = 1;       hi = thr - 1; end
      1: begin lo = thr;     hi = thr + 2; end
      2: begin lo = 1;       hi = 3;       end
      default: begin lo = thr + 1; hi = thr + 6; end
    endcase
    if (lo < 1) lo = 1;
    if (lo > 40) lo = 40;
    if (hi > 40) hi = 40;
    if (hi < lo) hi = lo;
    return $urandom_range(lo, hi);
  endfunction

  // Drift the dial with jitter, with an occasional jump anywhere
  function automatic logic [ANGLE_BITS-1:0] next_angle();
    if ($urandom_range(0, 19) == 0)
      dial_pos = ANGLE_BITS'($urandom);
    else
      dial_pos = dial_pos + ANGLE_BITS'(dial_drift + int'($urandom_range(0, 64)) - 32);
    return dial_pos;
  endfunction

  // Present one tick; returns at the edge that accepts it
  task automatic send_tick(bit pressed, logic [ANGLE_BITS-1:0] angle, bit faulted);
    int gap;
    gap = send_calm ? 0 : pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid          <= 1'b1;
    in_button_pressed <= pressed;
    in_dial_angle     <= angle;
    in_motor_faulted  <= faulted;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid and wait until every owed result is in
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Write all three registers; called on a falling edge with the block idle
  task automatic configure(logic [CFG_W-1:0] hold, logic [CFG_W-1:0] tap,
                           logic [CFG_W-1:0] band);
    cfg_write_en <= 1'b1;
    cfg_index    <= bgdc_pkg::CFG_HOLD_TICKS;
    cfg_data     <= hold;
    sb.set_reg(bgdc_pkg::CFG_HOLD_TICKS, hold);
    @(negedge clk);
    cfg_index <= bgdc_pkg::CFG_TAP_WINDOW_TICKS;
    cfg_data  <= tap;
    sb.set_reg(bgdc_pkg::CFG_TAP_WINDOW_TICKS, tap);
    @(negedge clk);
    cfg_index <= bgdc_pkg::CFG_SEND_DEADBAND;
    cfg_data  <= band;
    sb.set_reg(bgdc_pkg::CFG_SEND_DEADBAND, band);
    @(negedge clk);
    cfg_write_en <= 1'b0;
  endtask

  // Press/release stretches sized around the thresholds, plus some bouncing
  task automatic play_gestures(int n_ticks);
    int sent, press_len, rel_len, k;
    bit fault;
    sent = 0;
    while (sent < n_ticks) begin
      dial_drift = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 1600)) - 800;
      fault = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 7) == 0) begin
        k = $urandom_range(1, 6);
        repeat (k) begin
          send_tick(1'($urandom_range(0, 1)), next_angle(), 1'($urandom_range(0, 1)));
          sent++;
        end
      end else begin
        press_len = pick_len(int'(sb.hold_ticks));
        rel_len   = pick_len(int'(sb.tap_window));
        repeat (press_len) begin
          send_tick(1'b1, next_angle(), fault ^ ($urandom_range(0, 15) == 0));
          sent++;
        end
        repeat (rel_len) begin
          send_tick(1'b0, next_angle(), fault ^ ($urandom_range(0, 15) == 0));
          sent++;
        end
      end
    end
    drain();
  endtask

  initial begin
    logic [CFG_W-1:0] hold_set[6];
    logic [CFG_W-1:0] tap_set[6];
    logic [CFG_W-1:0] band_set[6];
    hold_set = '{16'd5, 16'd0, 16'd1, 16'd12, 16'd65535, 16'd3000};
    tap_set  = '{16'd6, 16'd0, 16'd1, 16'd9, 16'd65535, 16'd300};
    band_set = '{16'd4, 16'd0, 16'd8192, 16'hFFFF, 16'd2, 16'd4};

    sb = new();
    sb.reset_model();
    rst_n             = 1'b0;
    in_valid          = 1'b0;
    in_button_pressed = 1'b0;
    in_dial_angle     = '0;
    in_motor_faulted  = 1'b0;
    out_ready         = 1'b0;
    cfg_write_en      = 1'b0;
    cfg_index         = bgdc_pkg::CFG_HOLD_TICKS;
    cfg_data          = '0;
    send_calm         = 1'b0;
    recv_calm         = 1'b0;
    dial_pos          = '0;
    dial_drift        = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset register values
    play_gestures(60);

    // directed: short thresholds so every gesture fits in a few ticks
    configure(16'd3, 16'd3, 16'd0);
    send_tick(1'b0, '0, 1'b0);
    repeat (3) send_tick(1'b1, '1, 1'b1);     // hold while faulted clears
    send_tick(1'b0, '1, 1'b1);                // consumed release is no tap
    repeat (3) send_tick(1'b1, '0, 1'b0);     // hold with no fault does nothing
    send_tick(1'b0, '0, 1'b0);
    send_tick(1'b1, '0, 1'b0);                // double tap
    send_tick(1'b0, '0, 1'b0);
    send_tick(1'b1, '0, 1'b0);
    send_tick(1'b0, '0, 1'b0);
    send_tick(1'b1, '0, 1'b0);                // lone tap enters velocity
    send_tick(1'b0, '0, 1'b0);
    send_tick(1'b0, '0, 1'b0);
    send_tick(1'b0, 14'd100, 1'b0);
    send_tick(1'b0, 14'd16383, 1'b0);         // backward across the seam
    send_tick(1'b0, 14'd0, 1'b0);             // forward across the seam
    send_tick(1'b0, 14'd8192, 1'b0);          // exactly half a turn each way
    send_tick(1'b0, 14'd0, 1'b0);
    send_tick(1'b0, 14'd8000, 1'b0);
    send_tick(1'b0, 14'd16000, 1'b0);         // clamp at the top
    send_tick(1'b0, 14'd7807, 1'b0);          // just past half a turn wraps
    send_tick(1'b1, 14'd7807, 1'b0);          // tap back to off
    send_tick(1'b0, 14'd7807, 1'b0);
    send_tick(1'b0, 14'd500, 1'b0);
    send_tick(1'b0, 14'd9000, 1'b0);          // toggle tick still accumulates
    drain();

    // random phases over fixed extremes, then random settings
    for (int ph = 0; ph < 8; ph++) begin
      send_calm = (ph % 3 == 1);
      recv_calm = (ph % 4 == 2);
      if (ph < 6)
        configure(hold_set[ph], tap_set[ph], band_set[ph]);
      else
        configure(CFG_W'($urandom_range(1, 30)), CFG_W'($urandom_range(1, 30)),
                  CFG_W'($urandom_range(0, 600)));
      play_gestures(145);
    end

    $display("Checked %0d ticks over reset values and nine register settings.", sb.checked);
    $display("Saw %0d fault clears, %0d double taps, %0d mode toggles, %0d command writes.",
             sb.clears, sb.double_taps, sb.toggles, sb.cmd_writes);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("button_gesture_and_dial_controller_unit: match");
    end else begin
      $display("%0d wrong results, %0d results never arrived",
               sb.mismatches, sb.expected_q.size());
      $display("button_gesture_and_dial_controller_unit: mismatch");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/bgdc_pkg.sv
design/bgdc_cfg.sv
design/bgdc_gesture.sv
design/bgdc_dial.sv
design/button_gesture_and_dial_controller_unit.sv
design/bgdc_checker.sv
test/tb_button_gesture_and_dial_controller_unit.sv
